>>> rtl/core/gdbd_pkg.sv
// Shared widths, types and calendar tables for the Gregorian day-count core.
`timescale 1ns / 1ps

package gdbd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;
    localparam int YY_W    = 15;  // shifted year, up to 16383 + 400
    localparam int Q_W     = 8;   // shifted year divided by 100
    localparam int MTERM_W = 9;   // day offset of a March-based month
    localparam int DPART_W = 10;  // month offset plus day of month
    localparam int DN_W    = 23;  // day number
    localparam int PROD_W  = 27;  // year times the reciprocal of 100

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    localparam logic [COUNT_W-1:0] DAY_COUNT_MAX = 22'd3652425;

    // floor(y / 100) == (y * 5243) >> 19 for every y below 32768.
    localparam logic [PROD_W-1:0] RECIP_100   = 27'd5243;
    localparam int                RECIP_SHIFT = 19;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        logic [YY_W-1:0]    yy;
        logic [Q_W-1:0]     q100;
        logic [MTERM_W-1:0] mterm;
        logic [DAY_W-1:0]   day;
        logic               ok;
    } t_front;

    // Length of a month; zero marks a month code outside the calendar.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_JAN: len = 5'd31;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_MAR: len = 5'd31;
            MONTH_APR: len = 5'd30;
            MONTH_MAY: len = 5'd31;
            MONTH_JUN: len = 5'd30;
            MONTH_JUL: len = 5'd31;
            MONTH_AUG: len = 5'd31;
            MONTH_SEP: len = 5'd30;
            MONTH_OCT: len = 5'd31;
            MONTH_NOV: len = 5'd30;
            MONTH_DEC: len = 5'd31;
            default:   len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of the month in a year that starts in March,
    // that is (153 * mm + 2) / 5 with mm counted from March.
    function automatic logic [MTERM_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [MTERM_W-1:0] off;
        case (m)
            MONTH_MAR: off = 9'd0;
            MONTH_APR: off = 9'd31;
            MONTH_MAY: off = 9'd61;
            MONTH_JUN: off = 9'd92;
            MONTH_JUL: off = 9'd122;
            MONTH_AUG: off = 9'd153;
            MONTH_SEP: off = 9'd184;
            MONTH_OCT: off = 9'd214;
            MONTH_NOV: off = 9'd245;
            MONTH_DEC: off = 9'd275;
            MONTH_JAN: off = 9'd306;
            MONTH_FEB: off = 9'd337;
            default:   off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

>>> rtl/core/gdbd_date_front.sv
// Front stages for one date: century quotient, leap rule and date check.
`timescale 1ns / 1ps

module gdbd_date_front (
    input  logic             i_clk,
    input  logic [1:0]       i_en,
    input  gdbd_pkg::t_date  i_date,
    output gdbd_pkg::t_front o_front
);
    import gdbd_pkg::*;

    t_date          r_date;
    logic [Q_W-1:0] r_q;
    t_front         r_front;

    logic [PROD_W-1:0]  w_prod;
    logic [YEAR_W-1:0]  w_hund;
    logic [YEAR_W-1:0]  w_rem;
    logic               w_cent;
    logic               w_leap;
    logic               w_early;
    logic [DAY_W-1:0]   w_len;
    t_front             n_front;

    // Stage one: divide the year by 100 through a reciprocal multiply.
    assign w_prod = PROD_W'(i_date.year) * RECIP_100;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_date <= i_date;
            r_q    <= w_prod[RECIP_SHIFT +: Q_W];
        end
    end

    // Stage two: remainder, leap year, validity and the shifted year.
    always_comb begin
        w_hund  = YEAR_W'(r_q) * YEAR_W'(100);
        w_rem   = r_date.year - w_hund;
        w_cent  = (w_rem == '0);
        w_leap  = (r_date.year[1:0] == 2'b00) && (!w_cent || r_date.year[3:0] == 4'b0000);
        w_early = (r_date.month <= MONTH_FEB);
        w_len   = month_len(r_date.month, w_leap);

        n_front.yy    = YY_W'(r_date.year) + YY_W'(400) - YY_W'(w_early);
        // (y + 399) / 100 drops by one only when y is a whole century.
        n_front.q100  = r_q + Q_W'(4) - Q_W'(w_early & w_cent);
        n_front.mterm = month_offset(r_date.month);
        n_front.day   = r_date.day;
        n_front.ok    = (w_len != '0) && (r_date.day != '0) && (r_date.day <= w_len);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

>>> rtl/core/gdbd_day_number.sv
// Day-number stages: year part and month-day part, then their sum.
`timescale 1ns / 1ps

module gdbd_day_number (
    input  logic                      i_clk,
    input  logic [1:0]                i_en,
    input  gdbd_pkg::t_front          i_front,
    output logic [gdbd_pkg::DN_W-1:0] o_dn,
    output logic                      o_ok
);
    import gdbd_pkg::*;

    logic [DN_W-1:0]    r_year_part;
    logic [DPART_W-1:0] r_day_part;
    logic               r_ok1;
    logic [DN_W-1:0]    r_dn;
    logic               r_ok2;

    logic [DN_W-1:0]    n_year_part;
    logic [DPART_W-1:0] n_day_part;

    // The constant minus one of the day number cancels in the difference
    // and is left out here.
    always_comb begin
        n_year_part = DN_W'(i_front.yy) * DN_W'(365) + DN_W'(i_front.yy >> 2)
                    + DN_W'(i_front.q100 >> 2) - DN_W'(i_front.q100);
        n_day_part  = DPART_W'(i_front.mterm) + DPART_W'(i_front.day);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_year_part <= n_year_part;
            r_day_part  <= n_day_part;
            r_ok1       <= i_front.ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_dn  <= r_year_part + DN_W'(r_day_part);
            r_ok2 <= r_ok1;
        end
    end

    assign o_dn = r_dn;
    assign o_ok = r_ok2;

endmodule

>>> rtl/core/gdbd_count.sv
// Final stage: difference of day numbers, end-day adjustment and saturation.
`timescale 1ns / 1ps

module gdbd_count (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [gdbd_pkg::DN_W-1:0]    i_dn_start,
    input  logic [gdbd_pkg::DN_W-1:0]    i_dn_end,
    input  logic                         i_ok,
    input  logic                         i_include_end,
    output logic [gdbd_pkg::COUNT_W-1:0] o_day_count,
    output logic                         o_invalid_date
);
    import gdbd_pkg::*;

    logic [COUNT_W-1:0] r_day_count;
    logic               r_invalid;

    logic [DN_W-1:0]    w_diff;
    logic [DN_W:0]      w_sum;
    logic [COUNT_W-1:0] n_day_count;

    always_comb begin
        w_diff = (i_dn_start < i_dn_end) ? (i_dn_end - i_dn_start) : '0;
        w_sum  = (DN_W + 1)'(w_diff) + (DN_W + 1)'(i_include_end);
        if (!i_ok) begin
            n_day_count = '0;
        end else if (w_sum > (DN_W + 1)'(DAY_COUNT_MAX)) begin
            n_day_count = DAY_COUNT_MAX;
        end else begin
            n_day_count = w_sum[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_day_count <= n_day_count;
            r_invalid   <= !i_ok;
        end
    end

    assign o_day_count    = r_day_count;
    assign o_invalid_date = r_invalid;

endmodule

>>> rtl/core/gregorian_days_between_dates_core.sv
// Top level of the Gregorian day-count core: stream ports and pipeline control.
`timescale 1ns / 1ps

// Each request carries a start date, an end date and an include-end flag, and
// gives one result: the number of days from start to end (plus one when the
// flag is set), or 0 (1 with the flag) when the start is not before the end.
// Leap years follow the 400/100/4 rule, year 0 included. A month outside
// 1..12 or a day outside its month in either date sets the invalid flag and
// forces the count to 0. Counts above 3652425 saturate there. The core is a
// five-stage pipeline that takes one request per clock when the output is
// not stalled. The stages are the reciprocal multiply for the century
// quotient, the leap rule and date check, the year and month parts of the
// day number, their sum, and the final subtract and saturate. Every stage
// holds its own valid bit, so a stalled output only stops the stages behind
// it once they are full; empty stages keep taking requests.

module gregorian_days_between_dates_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // From bit 0 up: start_year[13:0], start_month[3:0], start_day[4:0],
    // end_year[13:0], end_month[3:0], end_day[4:0], include_end, one zero bit.
    input  logic [gdbd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // From bit 0 up: day_count[21:0], two zero bits.
    output logic [gdbd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // invalid_date.
    output logic                              m_axis_tuser
);
    import gdbd_pkg::*;

    localparam int NSTAGE = 5;

    logic [NSTAGE-1:0] r_valid;
    logic [NSTAGE-1:0] w_en;
    logic [NSTAGE-2:0] r_inc;

    t_date              w_start;
    t_date              w_end;
    t_front             w_front_start;
    t_front             w_front_end;
    logic [DN_W-1:0]    w_dn_start;
    logic [DN_W-1:0]    w_dn_end;
    logic               w_ok_start;
    logic               w_ok_end;
    logic [COUNT_W-1:0] w_day_count;
    logic               w_invalid;

    // Unpack the request.
    assign w_start.year  = s_axis_tdata[13:0];
    assign w_start.month = s_axis_tdata[17:14];
    assign w_start.day   = s_axis_tdata[22:18];
    assign w_end.year    = s_axis_tdata[36:23];
    assign w_end.month   = s_axis_tdata[40:37];
    assign w_end.day     = s_axis_tdata[45:41];

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        w_en[NSTAGE-1] = !r_valid[NSTAGE-1] || m_axis_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // The include-end flag rides alongside the first four stages.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_inc[0] <= s_axis_tdata[46];
        end
        for (int k = 1; k < NSTAGE - 1; k++) begin
            if (w_en[k]) begin
                r_inc[k] <= r_inc[k-1];
            end
        end
    end

    gdbd_date_front u_front_start (
        .i_clk   (i_clk),
        .i_en    (w_en[1:0]),
        .i_date  (w_start),
        .o_front (w_front_start)
    );

    gdbd_date_front u_front_end (
        .i_clk   (i_clk),
        .i_en    (w_en[1:0]),
        .i_date  (w_end),
        .o_front (w_front_end)
    );

    gdbd_day_number u_dn_start (
        .i_clk   (i_clk),
        .i_en    (w_en[3:2]),
        .i_front (w_front_start),
        .o_dn    (w_dn_start),
        .o_ok    (w_ok_start)
    );

    gdbd_day_number u_dn_end (
        .i_clk   (i_clk),
        .i_en    (w_en[3:2]),
        .i_front (w_front_end),
        .o_dn    (w_dn_end),
        .o_ok    (w_ok_end)
    );

    gdbd_count u_count (
        .i_clk          (i_clk),
        .i_en           (w_en[4]),
        .i_dn_start     (w_dn_start),
        .i_dn_end       (w_dn_end),
        .i_ok           (w_ok_start && w_ok_end),
        .i_include_end  (r_inc[NSTAGE-2]),
        .o_day_count    (w_day_count),
        .o_invalid_date (w_invalid)
    );

    assign m_axis_tvalid = r_valid[NSTAGE-1];
    assign m_axis_tdata  = OUT_DATA_W'(w_day_count);
    assign m_axis_tuser  = w_invalid;

endmodule

>>> tb/tb_gregorian_days_between_dates_core.sv
// Self-checking testbench for the Gregorian day-count core with a scoreboard class.
`timescale 1ns / 1ps

// Every request carries two dates and an include-end flag. The scoreboard
// works out the expected day count from day numbers of its own and queues it
// when the request is accepted. Each result leaving the core is compared with
// the oldest queued count. The stimulus opens with hand-picked dates: the ends
// of the year range, leap days in leap and common years, bad months and days,
// a start after the end and counts that saturate. Random requests follow,
// mostly well-formed dates with a share of corrupted ones and raw noise.

module tb_gregorian_days_between_dates_core;

    import gdbd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;  // well beyond the five-stage pipeline
    localparam int HOLD_CYCLES = 300;

    class day_count_tracker;

        typedef struct {
            logic [COUNT_W-1:0] day_count;
            logic               invalid_date;
        } t_span;

        t_span       pending_spans[$];
        int unsigned results_checked = 0;
        int unsigned invalid_seen    = 0;
        int unsigned saturated_seen  = 0;
        int unsigned mismatches      = 0;

        static function bit leap_year(int unsigned y);
            return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        endfunction

        // Zero marks a month code that is not a month.
        static function int unsigned month_length(int unsigned m, int unsigned y);
            if (m < MONTH_JAN || m > MONTH_DEC)
                return 0;
            if (m == MONTH_FEB)
                return leap_year(y) ? 29 : 28;
            if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
                return 30;
            return 31;
        endfunction

        static function bit date_valid(int unsigned y, int unsigned m, int unsigned d);
            int unsigned len;
            len = month_length(m, y);
            return len != 0 && d >= 1 && d <= len;
        endfunction

        // Days since a fixed epoch, with the year starting in March so that the
        // leap day falls at its end. The 400-year offset keeps every term positive.
        static function int unsigned epoch_day(int unsigned y, int unsigned m,
                                               int unsigned d);
            int unsigned yy;
            int unsigned mm;
            yy = y + 400;
            if (m <= MONTH_FEB) begin
                yy = yy - 1;
                mm = m + 9;
            end else begin
                mm = m - 3;
            end
            return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mm + 2) / 5 + d - 1;
        endfunction

        function t_span predict_span(logic [IN_DATA_W-1:0] req);
            t_span       s;
            int unsigned sy, sm, sd, ey, em, ed;
            int unsigned from_day, to_day, span;
            sy = req[13:0];
            sm = req[17:14];
            sd = req[22:18];
            ey = req[36:23];
            em = req[40:37];
            ed = req[45:41];
            if (!date_valid(sy, sm, sd) || !date_valid(ey, em, ed)) begin
                s.day_count    = '0;
                s.invalid_date = 1'b1;
                return s;
            end
            from_day = epoch_day(sy, sm, sd);
            to_day   = epoch_day(ey, em, ed);
            span     = (from_day < to_day) ? to_day - from_day : 0;
            span     = span + req[46];
            if (span > DAY_COUNT_MAX)
                span = DAY_COUNT_MAX;
            s.day_count    = span[COUNT_W-1:0];
            s.invalid_date = 1'b0;
            return s;
        endfunction

        function void note_request(logic [IN_DATA_W-1:0] req);
            pending_spans.push_back(predict_span(req));
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic flag);
            t_span want;
            if (pending_spans.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result count=%0d invalid=%0b with no request pending",
                             data[COUNT_W-1:0], flag);
                return;
            end
            want = pending_spans.pop_front();
            results_checked++;
            if (want.invalid_date)
                invalid_seen++;
            if (want.day_count == DAY_COUNT_MAX)
                saturated_seen++;
            if (data[COUNT_W-1:0] !== want.day_count || flag !== want.invalid_date) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result %0d: expected count=%0d invalid=%0b, ",
                              "got count=%0d invalid=%0b"},
                             results_checked, want.day_count, want.invalid_date,
                             data[COUNT_W-1:0], flag);
            end
        endfunction

        function int unsigned pending();
            return pending_spans.size();
        endfunction

    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // From bit 0 up: start_year, start_month, start_day, end_year, end_month,
    // end_day, include_end, one zero bit.
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // From bit 0 up: day_count, two zero bits.
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // invalid_date.
    logic                  m_axis_tuser;

    day_count_tracker tracker;
    int unsigned      cycle_count     = 0;
    bit               tx_idle_on      = 1'b0;
    bit               rx_idle_on      = 1'b0;
    int unsigned      rx_hold_request = 0;

    gregorian_days_between_dates_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Both handshakes are sampled at the edge, before any update of that edge
    // lands. A request is noted before a result is checked, so a result that
    // leaves in the same cycle as a newer request is still matched in order.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            tracker.note_request(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata, m_axis_tuser);
    end

    // The receiver: a long hold when one is asked for, counted here, and
    // otherwise random stalls while idling is switched on.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_request != 0) begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= !(rx_idle_on && $urandom_range(99) < 14);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ERROR: run stopped after %0d cycles", cycle_count);
        $display("tb_gregorian_days_between_dates_core NOT OK");
        $finish;
    end

    function automatic logic [IN_DATA_W-1:0] make_request(
        int unsigned sy, int unsigned sm, int unsigned sd,
        int unsigned ey, int unsigned em, int unsigned ed, bit inc);
        return {1'b0, inc, DAY_W'(ed), MONTH_W'(em), YEAR_W'(ey),
                DAY_W'(sd), MONTH_W'(sm), YEAR_W'(sy)};
    endfunction

    function automatic int unsigned random_year();
        if ($urandom_range(9) == 0)
            return $urandom_range(16383);
        return $urandom_range(9999);
    endfunction

    function automatic int unsigned random_day(int unsigned m, int unsigned y);
        return $urandom_range(day_count_tracker::month_length(m, y), 1);
    endfunction

    // Mostly well-formed date pairs, often within one year or one month so
    // that short spans are common; about a tenth have one field spoilt and a
    // few are raw noise over every bit but the top one.
    function automatic logic [IN_DATA_W-1:0] random_request();
        int unsigned kind;
        int unsigned sy, sm, sd, ey, em, ed;
        bit          inc;
        kind = $urandom_range(99);
        inc  = $urandom_range(1);
        if (kind < 8)
            return {1'b0, 15'($urandom), $urandom};
        sy = random_year();
        sm = $urandom_range(12, 1);
        sd = random_day(sm, sy);
        if (kind < 35) begin
            ey = sy;
            em = $urandom_range(1) ? sm : $urandom_range(12, 1);
        end else begin
            ey = random_year();
            em = $urandom_range(12, 1);
        end
        ed = random_day(em, ey);
        if (kind >= 90) begin
            case ($urandom_range(3))
                0: sm = $urandom_range(15);
                1: sd = $urandom_range(31);
                2: em = $urandom_range(15);
                default: ed = $urandom_range(31);
            endcase
        end
        return make_request(sy, sm, sd, ey, em, ed, inc);
    endfunction

    // Offers one request and returns at the edge that accepts it; tvalid stays
    // high so that a following request continues without a gap.
    task automatic send_request(input logic [IN_DATA_W-1:0] req);
        while (tx_idle_on && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic send_random(input int unsigned n);
        repeat (n) send_request(random_request());
    endtask

    // One edge passes first so that the request accepted at the current edge
    // has surely been noted before the queue is looked at.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_directed();
        // Same date, with and without the end day counted.
        send_request(make_request(2024, 5, 17, 2024, 5, 17, 1'b0));
        send_request(make_request(2024, 5, 17, 2024, 5, 17, 1'b1));
        // The whole year range 0..9999, landing exactly on the ceiling with the flag.
        send_request(make_request(0, 1, 1, 9999, 12, 31, 1'b0));
        send_request(make_request(0, 1, 1, 9999, 12, 31, 1'b1));
        // Years beyond 9999 push the count past the ceiling; reversed, it is 1.
        send_request(make_request(0, 1, 1, 16383, 12, 31, 1'b0));
        send_request(make_request(16383, 12, 31, 0, 1, 1, 1'b1));
        // Start after the end.
        send_request(make_request(2001, 3, 1, 2000, 3, 1, 1'b0));
        send_request(make_request(2001, 3, 1, 2000, 3, 1, 1'b1));
        // Leap days: century rule, 400-year rule, year zero, a common year.
        send_request(make_request(2000, 2, 29, 2000, 3, 1, 1'b0));
        send_request(make_request(1900, 2, 29, 1900, 3, 1, 1'b0));
        send_request(make_request(0, 2, 29, 4, 2, 29, 1'b1));
        send_request(make_request(2023, 2, 29, 2024, 2, 29, 1'b0));
        send_request(make_request(1899, 12, 31, 1900, 3, 1, 1'b0));
        // Bad months and days in either date, the flag ignored; then start after end.
        send_request(make_request(2020, 0, 10, 2021, 1, 1, 1'b1));
        send_request(make_request(2020, 13, 10, 2021, 1, 1, 1'b0));
        send_request(make_request(2020, 1, 10, 2021, 15, 1, 1'b1));
        send_request(make_request(2020, 1, 0, 2021, 1, 1, 1'b0));
        send_request(make_request(2020, 4, 31, 2021, 1, 31, 1'b1));
        send_request(make_request(2020, 1, 31, 2021, 6, 31, 1'b0));
        send_request(make_request(16383, 15, 31, 16383, 15, 31, 1'b1));
        send_request(make_request(9999, 12, 31, 9999, 12, 30, 1'b1));
    endtask

    initial begin
        tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_directed();
        send_random(600);

        // The receiver holds off while the sender keeps offering requests, so
        // the pipeline fills and stalls its input; then the sender pauses
        // until every outstanding request has given its result.
        wait_drained();
        rx_hold_request = HOLD_CYCLES;
        tx_idle_on      = 1'b0;
        send_random(60);
        wait_drained();

        // A long stretch at full rate on both sides.
        rx_idle_on = 1'b0;
        send_random(500);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_random(640);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d day counts (%0d with a bad date, %0d at the ceiling), %0d wrong.",
                 tracker.results_checked, tracker.invalid_seen, tracker.saturated_seen,
                 tracker.mismatches);
        $display("Stimulus: hand-picked dates, random date pairs, a %0d-cycle output hold, %s",
                 HOLD_CYCLES, "full-rate and idling stretches.");
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb_gregorian_days_between_dates_core OK");
        end else begin
            if (tracker.pending() != 0)
                $display("ERROR: %0d results never arrived", tracker.pending());
            $display("tb_gregorian_days_between_dates_core NOT OK");
        end
        $finish;
    end

endmodule
